[rtl/canonical_huffman_codec_assert.svh]
// assertion macros used by the port checker file
`ifndef CANONICAL_HUFFMAN_CODEC_ASSERT_SVH
`define CANONICAL_HUFFMAN_CODEC_ASSERT_SVH

// property must hold at every clock edge out of reset
`define CHC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// a value must not change in the cycle after the condition
`define CHC_ASSERT_HOLD(label, clk, rstn, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
        else $error("held value changed");

`endif

[rtl/chc_pkg.sv]
// ----------------------------------------------------------------------------
// chc_pkg
// shared types and constants of the canonical huffman codec
// ----------------------------------------------------------------------------
`default_nettype none

package chc_pkg;

    localparam int MaxSymbols  = 512;
    localparam int MaxCodeBits = 15;
    localparam int SymW        = 9;
    localparam int CountW      = 10;
    localparam int LenW        = 4;
    localparam int CodeW       = 15;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_DECODE = 2'd2,
        OP_LOOKUP = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT,
        S_CHECK,
        S_PREP,
        S_ASG_RD,
        S_ASG,
        S_LK_RD,
        S_LK,
        S_DEC_RD,
        S_DEC,
        S_OUT
    } state_t;

    // result item
    typedef struct packed {
        logic [CodeW-1:0] code_bits;
        logic [LenW-1:0]  out_length;
        logic             complete;
        logic [SymW-1:0]  symbol;
        logic [1:0]       status;
    } result_t;

    // bit-reverse the low len bits of a code
    function automatic logic [CodeW-1:0] rev_code(input logic [CodeW-1:0] c,
                                                  input logic [LenW-1:0] len);
        logic [CodeW-1:0] r;
        r = '0;
        for (int k = 0; k < CodeW; k++) begin
            if (k < int'(len)) begin
                r[int'(len) - 1 - k] = c[k];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/chc_tables.sv]
// ----------------------------------------------------------------------------
// chc_tables
// symbol memories: loaded lengths, built length and code, sorted symbols
// ----------------------------------------------------------------------------
`default_nettype none

module chc_tables (
    input  wire logic                      aclk,
    input  wire logic                      len_we,
    input  wire logic [chc_pkg::SymW-1:0]  len_waddr,
    input  wire logic [chc_pkg::LenW-1:0]  len_wdata,
    input  wire logic [chc_pkg::SymW-1:0]  len_raddr,
    output logic      [chc_pkg::LenW-1:0]  len_rdata,
    input  wire logic                      code_we,
    input  wire logic [chc_pkg::SymW-1:0]  code_waddr,
    input  wire logic [chc_pkg::LenW+chc_pkg::CodeW-1:0] code_wdata,
    input  wire logic [chc_pkg::SymW-1:0]  code_raddr,
    output logic      [chc_pkg::LenW+chc_pkg::CodeW-1:0] code_rdata,
    input  wire logic                      sort_we,
    input  wire logic [chc_pkg::SymW-1:0]  sort_waddr,
    input  wire logic [chc_pkg::SymW-1:0]  sort_wdata,
    input  wire logic [chc_pkg::SymW-1:0]  sort_raddr,
    output logic      [chc_pkg::SymW-1:0]  sort_rdata
);

    logic [chc_pkg::LenW-1:0] len_mem [chc_pkg::MaxSymbols];
    logic [chc_pkg::LenW+chc_pkg::CodeW-1:0] code_mem [chc_pkg::MaxSymbols];
    logic [chc_pkg::SymW-1:0] sort_mem [chc_pkg::MaxSymbols];

    // loaded lengths
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

    // built length and reversed code
    always_ff @(posedge aclk) begin
        if (code_we) begin
            code_mem[code_waddr] <= code_wdata;
        end
        code_rdata <= code_mem[code_raddr];
    end

    // symbols sorted by length
    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rdata <= sort_mem[sort_raddr];
    end

endmodule

`default_nettype wire

[rtl/canonical_huffman_codec.sv]
// ----------------------------------------------------------------------------
// canonical_huffman_codec
// deflate-style canonical huffman table builder, bit decoder and encoder lookup
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low first)                       | tuser
// s_      | in  | symbol_index, code_length, symbol_count, bit_value | opcode
// m_      | out | symbol, complete, out_length, code_bits         | status
//
// decode: one memory read of the sorted table per bit; build: clear of all 512
// code entries, count walk, length check, prep of first slots and codes,
// assign walk and output, in that order (count and assign walks skip if n = 0).
// reset: clears counts and decoder state; memories need no clearing.
// a finished result waits in the output register; the next request is taken
// only once it has gone.
`default_nettype none

module canonical_huffman_codec (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // symbol_index[8:0], code_length[12:9], symbol_count[22:13], bit_value[23]
    input  wire logic [23:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // symbol[8:0], complete[9], out_length[13:10], code_bits[28:14], zero[31:29]
    output logic [31:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser
);

    localparam int SW = chc_pkg::SymW;
    localparam int CW = chc_pkg::CountW;
    localparam int LW = chc_pkg::LenW;
    localparam int BW = chc_pkg::CodeW;

    chc_pkg::state_t state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [LW-1:0] len_reg, len_next;
    logic [CW-1:0] n_reg, n_next;
    logic          bit_reg, bit_next;
    logic [CW-1:0] cnt_reg [16];
    logic [CW-1:0] cnt_next [16];
    logic [CW-1:0] slot_reg [16];
    logic [CW-1:0] slot_next [16];
    logic [BW:0]   nc_reg [16];
    logic [BW:0]   nc_next [16];
    logic [CW-1:0] i_reg, i_next;
    logic [4:0]    k_reg, k_next;
    logic signed [17:0] room_reg, room_next;
    logic          bad_reg, bad_next;
    logic [BW-1:0] acc_reg, acc_next;
    logic [15:0]   base_reg, base_next;
    logic [CW-1:0] off_reg, off_next;
    logic [LW:0]   dep_reg, dep_next;
    chc_pkg::result_t res_reg, res_next;
    logic          mv_reg, mv_next;

    logic          len_we, code_we, sort_we;
    logic [SW-1:0] len_raddr, code_addr, sort_waddr, sort_raddr;
    logic [SW-1:0] sort_wdata;
    logic [LW+BW-1:0] code_wdata, code_rdata;
    logic [LW-1:0] len_rdata;
    logic [SW-1:0] sort_rdata_w;

    chc_tables u_tables (
        .aclk       (aclk),
        .len_we     (len_we),
        .len_waddr  (idx_reg),
        .len_wdata  (len_reg),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata),
        .code_we    (code_we),
        .code_waddr (code_addr),
        .code_wdata (code_wdata),
        .code_raddr (code_addr),
        .code_rdata (code_rdata),
        .sort_we    (sort_we),
        .sort_waddr (sort_waddr),
        .sort_wdata (sort_wdata),
        .sort_raddr (sort_raddr),
        .sort_rdata (sort_rdata_w)
    );

    assign s_tready = (state_reg == chc_pkg::S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, res_reg.code_bits, res_reg.out_length, res_reg.complete,
                       res_reg.symbol};
    assign m_tuser  = res_reg.status;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chc_pkg::S_IDLE;
            mv_reg    <= 1'b0;
            acc_reg   <= '0;
            base_reg  <= '0;
            off_reg   <= '0;
            dep_reg   <= (LW+1)'(1);
            for (int j = 0; j < 16; j++) begin
                cnt_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            off_reg   <= off_next;
            dep_reg   <= dep_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        n_reg    <= n_next;
        bit_reg  <= bit_next;
        slot_reg <= slot_next;
        nc_reg   <= nc_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        room_reg <= room_next;
        bad_reg  <= bad_next;
        res_reg  <= res_next;
    end

    // sequencer
    always_comb begin
        logic [BW-1:0] acc_w;
        logic [15:0]   sum_w;
        logic [CW-1:0] lc;
        logic [LW-1:0] ln;
        state_next = state_reg;
        op_next = op_reg; idx_next = idx_reg; len_next = len_reg;
        n_next = n_reg; bit_next = bit_reg;
        cnt_next = cnt_reg; slot_next = slot_reg; nc_next = nc_reg;
        i_next = i_reg; k_next = k_reg; room_next = room_reg; bad_next = bad_reg;
        acc_next = acc_reg; base_next = base_reg; off_next = off_reg; dep_next = dep_reg;
        res_next = res_reg; mv_next = mv_reg;
        len_we = 1'b0; code_we = 1'b0; sort_we = 1'b0;
        len_raddr = i_reg[SW-1:0];
        code_addr = idx_reg;
        code_wdata = '0;
        sort_waddr = slot_reg[len_rdata][SW-1:0];
        sort_wdata = i_reg[SW-1:0];
        sort_raddr = '0;
        acc_w = '0; sum_w = '0; lc = '0; ln = '0;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            chc_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next  = s_tuser;
                    idx_next = s_tdata[8:0];
                    len_next = s_tdata[12:9];
                    n_next   = s_tdata[22:13];
                    bit_next = s_tdata[23];
                    i_next   = '0;
                    res_next = '0;
                    unique case (chc_pkg::opcode_t'(s_tuser))
                        chc_pkg::OP_LOAD:   state_next = chc_pkg::S_OUT;
                        chc_pkg::OP_BUILD: begin
                            if (s_tdata[22:13] > CW'(chc_pkg::MaxSymbols)) begin
                                res_next.status = chc_pkg::ST_RANGE;
                                state_next = chc_pkg::S_OUT;
                            end else begin
                                state_next = chc_pkg::S_CLR;
                            end
                        end
                        chc_pkg::OP_DECODE: state_next = chc_pkg::S_DEC_RD;
                        default:            state_next = chc_pkg::S_LK_RD;
                    endcase
                end
            end
            chc_pkg::S_OUT: begin
                // load lands here; write the length store
                if (op_reg == chc_pkg::OP_LOAD) begin
                    len_we = 1'b1;
                end
                mv_next = 1'b1;
                state_next = chc_pkg::S_IDLE;
            end
            chc_pkg::S_CLR: begin
                // clear built codes, one entry a cycle
                code_addr  = i_reg[SW-1:0];
                code_we    = 1'b1;
                code_wdata = '0;
                acc_next = '0; base_next = '0; off_next = '0; dep_next = (LW+1)'(1);
                for (int j = 0; j < 16; j++) begin
                    cnt_next[j] = '0;
                end
                if (i_reg == CW'(chc_pkg::MaxSymbols - 1)) begin
                    i_next = '0;
                    state_next = (n_reg == '0) ? chc_pkg::S_CHECK : chc_pkg::S_CNT_RD;
                    k_next = 5'd1;
                    room_next = 18'sd1;
                    bad_next = 1'b0;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            chc_pkg::S_CNT_RD: begin
                len_raddr = i_reg[SW-1:0];
                state_next = chc_pkg::S_CNT;
            end
            chc_pkg::S_CNT: begin
                cnt_next[len_rdata] = cnt_reg[len_rdata] + 1'b1;
                if (i_reg + 1'b1 == n_reg) begin
                    state_next = chc_pkg::S_CHECK;
                    i_next = '0;
                    k_next = 5'd1;
                    room_next = 18'sd1;
                    bad_next = 1'b0;
                end else begin
                    i_next = i_reg + 1'b1;
                    len_raddr = SW'(i_reg + 1'b1);
                end
            end
            chc_pkg::S_CHECK: begin
                // one length per cycle: double the room, take the count
                if (k_reg == 5'd16 || bad_reg) begin
                    if (bad_reg) begin
                        for (int j = 0; j < 16; j++) begin
                            cnt_next[j] = '0;
                        end
                        res_next.status = chc_pkg::ST_OVER;
                        state_next = chc_pkg::S_OUT;
                    end else begin
                        res_next.complete = (room_reg == 18'sd0);
                        state_next = chc_pkg::S_PREP;
                        k_next = 5'd1;
                        slot_next[1] = '0;
                        nc_next[1] = '0;
                        nc_next[0] = '0;
                        slot_next[0] = '0;
                    end
                end else begin
                    room_next = (room_reg <<< 1) - $signed({8'd0, cnt_reg[k_reg[3:0]]});
                    if ((room_reg <<< 1) - $signed({8'd0, cnt_reg[k_reg[3:0]]}) < 18'sd0) begin
                        bad_next = 1'b1;
                    end
                    k_next = k_reg + 1'b1;
                end
            end
            chc_pkg::S_PREP: begin
                // first slot and first code for each length
                if (k_reg == 5'd15) begin
                    i_next = '0;
                    state_next = (n_reg == '0) ? chc_pkg::S_OUT : chc_pkg::S_ASG_RD;
                end else begin
                    slot_next[k_reg[3:0] + 1'b1] = slot_reg[k_reg[3:0]] + cnt_reg[k_reg[3:0]];
                    nc_next[k_reg[3:0] + 1'b1] =
                        (BW+1)'((nc_reg[k_reg[3:0]] + (BW+1)'(cnt_reg[k_reg[3:0]])) << 1);
                    k_next = k_reg + 1'b1;
                end
            end
            chc_pkg::S_ASG_RD: begin
                len_raddr = i_reg[SW-1:0];
                state_next = chc_pkg::S_ASG;
            end
            chc_pkg::S_ASG: begin
                ln = len_rdata;
                if (ln != '0) begin
                    sort_we = (slot_reg[ln] < CW'(chc_pkg::MaxSymbols));
                    slot_next[ln] = slot_reg[ln] + 1'b1;
                    nc_next[ln] = nc_reg[ln] + 1'b1;
                    code_addr = i_reg[SW-1:0];
                    code_we = 1'b1;
                    code_wdata = {ln, chc_pkg::rev_code(nc_reg[ln][BW-1:0], ln)};
                end
                if (i_reg + 1'b1 == n_reg) begin
                    state_next = chc_pkg::S_OUT;
                end else begin
                    i_next = i_reg + 1'b1;
                    len_raddr = SW'(i_reg + 1'b1);
                end
            end
            chc_pkg::S_LK_RD: begin
                state_next = chc_pkg::S_LK;
            end
            chc_pkg::S_LK: begin
                res_next.out_length = code_rdata[LW+BW-1:BW];
                res_next.code_bits  = code_rdata[BW-1:0];
                mv_next = 1'b1;
                state_next = chc_pkg::S_IDLE;
            end
            chc_pkg::S_DEC_RD: begin
                // read sorted entry for the candidate slot
                lc = cnt_reg[dep_reg[3:0]];
                acc_w = {acc_reg[BW-2:0], bit_reg};
                sort_raddr = SW'(off_reg + CW'(16'(acc_w) - base_reg));
                state_next = chc_pkg::S_DEC;
            end
            chc_pkg::S_DEC: begin
                lc = cnt_reg[dep_reg[3:0]];
                acc_w = {acc_reg[BW-2:0], bit_reg};
                sum_w = base_reg + 16'(lc);
                state_next = chc_pkg::S_IDLE;
                if (16'(acc_w) < sum_w) begin
                    res_next.symbol = (off_reg + CW'(16'(acc_w) - base_reg)
                                       < CW'(chc_pkg::MaxSymbols)) ? sort_rdata_w : '0;
                    acc_next = '0; base_next = '0; off_next = '0; dep_next = (LW+1)'(1);
                    mv_next = 1'b1;
                end else if (dep_reg == (LW+1)'(chc_pkg::MaxCodeBits)) begin
                    res_next.status = chc_pkg::ST_NOMATCH;
                    acc_next = '0; base_next = '0; off_next = '0; dep_next = (LW+1)'(1);
                    mv_next = 1'b1;
                end else begin
                    acc_next = acc_w;
                    off_next = off_reg + lc;
                    base_next = 16'(sum_w << 1);
                    dep_next = dep_reg + 1'b1;
                end
            end
            default: state_next = chc_pkg::S_IDLE;
        endcase
        if (state_reg == chc_pkg::S_IDLE) begin
            code_addr = s_tdata[8:0];
        end
        if (state_reg == chc_pkg::S_ASG) begin
            sort_waddr = slot_reg[len_rdata][SW-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/chc_checker.sv]
// ----------------------------------------------------------------------------
// chc_checker
// port-level checks of the codec handshake and results
// ----------------------------------------------------------------------------
`default_nettype none
`include "canonical_huffman_codec_assert.svh"

module chc_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    logic err_res;

    // result that carries an error status
    assign err_res = m_tvalid && (m_tuser != chc_pkg::ST_OK);

    // one request at a time: no intake while a result waits
    `CHC_ASSERT(a_no_take_busy, aclk, aresetn, m_tvalid |-> !s_tready)
    // a stalled result holds
    `CHC_ASSERT_HOLD(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tdata)
    // padding bits stay zero
    `CHC_ASSERT(a_pad, aclk, aresetn, m_tvalid |-> m_tdata[31:29] == 3'b000)
    // an error result carries no symbol
    `CHC_ASSERT(a_err_sym, aclk, aresetn, err_res |-> m_tdata[8:0] == 9'd0)

endmodule

bind canonical_huffman_codec chc_port_checker u_chc_checker (.*);

`default_nettype wire

[sim/chc_checker.sv]
// ----------------------------------------------------------------------------
// chc_checker
// watches both channels of the huffman codec, predicts every result from the
// accepted requests and compares the results field by field in order
// ----------------------------------------------------------------------------
`default_nettype none

module chc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // predictor state
    logic [3:0]  len_mem [chc_pkg::MaxSymbols];
    int          cnt     [16];
    logic [8:0]  sorted  [chc_pkg::MaxSymbols];
    logic [14:0] code_mem[chc_pkg::MaxSymbols];
    logic [3:0]  built_len[chc_pkg::MaxSymbols];
    int          acc, base, offs, depth;

    chc_pkg::result_t expected_q[$];

    initial errors = 0;
    assign pending = expected_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic push(input chc_pkg::status_t st, input int sym, input int cpl,
                        input int len, input int code);
        chc_pkg::result_t r;
        r.status     = st;
        r.symbol     = sym[8:0];
        r.complete   = cpl[0];
        r.out_length = len[3:0];
        r.code_bits  = code[14:0];
        expected_q.push_back(r);
    endtask

    function automatic void restart_decoder();
        acc = 0;
        base = 0;
        offs = 0;
        depth = 1;
    endfunction

    // table build: count, kraft check, canonical assignment
    task automatic predict_build(input int n);
        int slot[17];
        int nxt[16];
        int room, len, c, rev;
        bit bad;
        room = 1;
        bad = 0;
        if (n > chc_pkg::MaxSymbols) begin
            push(chc_pkg::ST_RANGE, 0, 0, 0, 0);
            return;
        end
        restart_decoder();
        foreach (cnt[i]) cnt[i] = 0;
        foreach (built_len[i]) begin
            built_len[i] = '0;
            code_mem[i] = '0;
        end
        for (int i = 0; i < n; i++) cnt[len_mem[i]]++;
        for (int i = 1; i <= chc_pkg::MaxCodeBits && !bad; i++) begin
            room = room * 2 - cnt[i];
            if (room < 0) bad = 1;
        end
        if (bad) begin
            foreach (cnt[i]) cnt[i] = 0;
            push(chc_pkg::ST_OVER, 0, 0, 0, 0);
            return;
        end
        slot[1] = 0;
        for (int i = 1; i < 16; i++) slot[i + 1] = slot[i] + cnt[i];
        nxt[0] = 0;
        nxt[1] = 0;
        for (int i = 2; i < 16; i++) nxt[i] = (nxt[i - 1] + cnt[i - 1]) << 1;
        for (int i = 0; i < n; i++) begin
            len = len_mem[i];
            if (len != 0) begin
                if (slot[len] < chc_pkg::MaxSymbols) sorted[slot[len]] = i[8:0];
                slot[len]++;
                c = nxt[len];
                nxt[len]++;
                rev = 0;
                for (int k = 0; k < len; k++) rev = (rev << 1) | ((c >> k) & 1);
                code_mem[i] = rev[14:0];
                built_len[i] = len[3:0];
            end
        end
        push(chc_pkg::ST_OK, 0, (room == 0) ? 1 : 0, 0, 0);
    endtask

    // one stream bit through the canonical decoder
    task automatic predict_decode(input int b);
        int len, idx, sym;
        len = cnt[depth & 15];
        acc = ((acc << 1) | b) & 'h7FFF;
        if (acc < base + len) begin
            idx = offs + (acc - base);
            sym = (idx < chc_pkg::MaxSymbols) ? int'(sorted[idx]) : 0;
            restart_decoder();
            push(chc_pkg::ST_OK, sym, 0, 0, 0);
            return;
        end
        offs = (offs + len) & 'h3FF;
        base = ((base + len) << 1) & 'hFFFF;
        depth++;
        if (depth > chc_pkg::MaxCodeBits) begin
            restart_decoder();
            push(chc_pkg::ST_NOMATCH, 0, 0, 0, 0);
        end
    endtask

    // inputs and outputs settle before the falling edge, so the handshake
    // seen here is the one taken at the next rising edge
    always @(negedge aclk) begin
        chc_pkg::result_t w;
        if (!aresetn) begin
            foreach (cnt[i]) cnt[i] = 0;
            restart_decoder();
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                case (chc_pkg::opcode_t'(s_tuser))
                    chc_pkg::OP_LOAD: begin
                        len_mem[s_tdata[8:0]] = s_tdata[12:9];
                        push(chc_pkg::ST_OK, 0, 0, 0, 0);
                    end
                    chc_pkg::OP_BUILD:  predict_build(int'(s_tdata[22:13]));
                    chc_pkg::OP_DECODE: predict_decode(int'(s_tdata[23]));
                    default: push(chc_pkg::ST_OK, 0, 0, int'(built_len[s_tdata[8:0]]),
                                  int'(code_mem[s_tdata[8:0]]));
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result status", int'(m_tuser), -1);
                end else begin
                    w = expected_q.pop_front();
                    if (m_tuser != w.status)
                        report("status", int'(m_tuser), int'(w.status));
                    if (m_tdata[8:0] != w.symbol)
                        report("symbol", int'(m_tdata[8:0]), int'(w.symbol));
                    if (m_tdata[9] != w.complete)
                        report("complete", int'(m_tdata[9]), int'(w.complete));
                    if (m_tdata[13:10] != w.out_length)
                        report("out_length", int'(m_tdata[13:10]), int'(w.out_length));
                    if (m_tdata[28:14] != w.code_bits)
                        report("code_bits", int'(m_tdata[28:14]), int'(w.code_bits));
                end
            end
        end
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives load, build, decode and lookup requests into the huffman codec:
// directed corner cases, then random code sets (mostly valid kraft-complete
// trees) each followed by a random bit stream and lookups
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2000000;
    localparam int TargetItems = 1550;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors, pending;
    int          items = 0;
    int          cycles = 0;
    bit          quiet = 0;

    always #6 aclk = ~aclk;

    canonical_huffman_codec dut (.*);

    chc_checker u_checker (.*);

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send(input chc_pkg::opcode_t op, input int idx, input int len,
                        input int n, input int b);
        bit rdy;
        if (!quiet && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b[0], n[9:0], len[3:0], idx[8:0]};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        items++;
        quiet = (items > 700 && items < 900);
    endtask

    // random code set over symbols 0..n-1, then a bit stream against it
    task automatic run_set(input int n);
        int plen[chc_pkg::MaxSymbols];
        int leaf[chc_pkg::MaxSymbols];
        int k, want, p, last, t, r;
        foreach (plen[i]) plen[i] = 0;
        if (n < 2) begin
            plen[0] = $urandom_range(0, 15);
        end else begin
            // grow a complete tree by splitting leaves
            leaf[0] = 1;
            leaf[1] = 1;
            k = 2;
            last = 1;
            want = $urandom_range(2, n);
            while (k < want) begin
                p = ($urandom_range(0, 3) == 0) ? last : $urandom_range(0, k - 1);
                if (leaf[p] < chc_pkg::MaxCodeBits) begin
                    leaf[p]++;
                    leaf[k] = leaf[p];
                    last = k;
                    k++;
                end
            end
            for (int i = 0; i < k; i++) plen[i] = leaf[i];
            for (int i = n - 1; i > 0; i--) begin
                r = $urandom_range(0, i);
                t = plen[i];
                plen[i] = plen[r];
                plen[r] = t;
            end
            // broken sets: a random length (may over-subscribe) or a missing leaf
            case ($urandom_range(0, 5))
                0: plen[$urandom_range(0, n - 1)] = $urandom_range(1, 15);
                1: plen[$urandom_range(0, n - 1)] = 0;
                default: ;
            endcase
        end
        for (int i = 0; i < n; i++) send(chc_pkg::OP_LOAD, i, plen[i], $urandom, $urandom);
        if ($urandom_range(0, 7) == 0)
            send(chc_pkg::OP_BUILD, $urandom, $urandom, $urandom_range(513, 1023), $urandom);
        send(chc_pkg::OP_BUILD, $urandom, $urandom, n, $urandom);
        repeat ($urandom_range(20, 60)) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send(chc_pkg::OP_DECODE, $urandom, $urandom, $urandom, $urandom);
            else if (r < 90)
                send(chc_pkg::OP_LOOKUP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                     : $urandom_range(0, n - 1), $urandom, $urandom, $urandom);
            else
                send(chc_pkg::OP_LOAD, $urandom_range(0, n - 1), $urandom, $urandom,
                     $urandom);
        end
    endtask

    initial begin
        int ex_len[8] = '{3, 3, 3, 3, 3, 2, 4, 4};
        int sets;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty code, out of range counts, a lookup and decodes on the empty code
        send(chc_pkg::OP_BUILD, 0, 0, 0, 0);
        send(chc_pkg::OP_BUILD, 0, 0, 1023, 0);
        send(chc_pkg::OP_BUILD, 511, 15, 513, 1);
        send(chc_pkg::OP_LOOKUP, 511, 0, 0, 0);
        repeat (15) send(chc_pkg::OP_DECODE, 0, 0, 0, 1);
        // textbook complete code, decode F then H, a lookup
        for (int i = 0; i < 8; i++) send(chc_pkg::OP_LOAD, i, ex_len[i], 0, 0);
        send(chc_pkg::OP_BUILD, 0, 0, 8, 0);
        send(chc_pkg::OP_DECODE, 0, 0, 0, 0);
        send(chc_pkg::OP_DECODE, 0, 0, 0, 0);
        repeat (4) send(chc_pkg::OP_DECODE, 0, 0, 0, 1);
        send(chc_pkg::OP_LOOKUP, 7, 0, 0, 0);
        // length reloaded after build: lookup keeps the built code
        send(chc_pkg::OP_LOAD, 0, 15, 0, 0);
        send(chc_pkg::OP_LOOKUP, 0, 0, 0, 0);
        // over-subscribed set, then decode runs out of bits
        send(chc_pkg::OP_LOAD, 1, 1, 0, 0);
        send(chc_pkg::OP_LOAD, 2, 1, 0, 0);
        send(chc_pkg::OP_LOAD, 0, 1, 0, 0);
        send(chc_pkg::OP_BUILD, 0, 0, 3, 0);
        repeat (15) send(chc_pkg::OP_DECODE, 0, 0, 0, 0);
        send(chc_pkg::OP_LOOKUP, 1, 0, 0, 0);
        send(chc_pkg::OP_LOAD, 511, 15, 0, 0);

        // random sets, one spanning the whole alphabet
        sets = 0;
        while (items < TargetItems) begin
            if (sets == 4)
                run_set(chc_pkg::MaxSymbols);
            else if ($urandom_range(0, 9) == 0)
                run_set(1);
            else
                run_set($urandom_range(2, 40));
            sets++;
        end
        s_tvalid <= 1'b0;

        // drain, then let a trailing decode bit settle
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/chc_pkg.sv
rtl/chc_tables.sv
rtl/canonical_huffman_codec.sv
rtl/chc_checker.sv
sim/chc_checker.sv
sim/tb_top.sv
